// ----- rtl/core/gge_pkg.sv -----
// ----------------------------------------------------------------------------
// Gray gradient edge map: shared types and constants
// Field widths, configuration register indexes, result kinds and the
// entry format passed from the front end to the result sequencer.
// ----------------------------------------------------------------------------
package gge_pkg;

    // Field widths
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 3 * CHAN_W;
    localparam int SUM_W     = 10;
    localparam int LEVEL_W   = 8;
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    // Widest column index supported by any line length.
    localparam int COL_MAX_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Register values after reset
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Division by three: floor(s / 3) == (s * 683) >> 11 for s <= 765.
    localparam int GRAY_RECIP   = 683;
    localparam int GRAY_SHIFT   = 11;
    localparam int GRAY_PROD_W  = 2 * SUM_W;

    // Largest level value, also the clamp for the gradient sum.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Which results one pixel causes.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,  // first row: nothing yet
        KIND_SELF  = 2'd1,  // one-row frame: own gray value
        KIND_ABOVE = 2'd2,  // pixel of the row above
        KIND_BOTH  = 2'd3   // last row: pixel above, then itself
    } t_kind;

    // One classified pixel on its way to the result sequencer.
    typedef struct packed {
        logic [COL_MAX_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic [LEVEL_W-1:0]   above_level;
        logic [LEVEL_W-1:0]   gray;
        t_kind                kind;
    } t_entry;

endpackage

// ----- rtl/core/gge_front.sv -----
// ----------------------------------------------------------------------------
// Gray gradient edge map: front end
// Accepts pixels, tracks the raster position, keeps the line buffer of
// gray values and classifies each pixel; pixels that cause results become queue entries.
// ----------------------------------------------------------------------------
module gge_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [gge_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gge_pkg::CFG_W-1:0]         i_cfg_data,
    // Pixel input
    input  logic                              i_pix_valid,
    output logic                              o_pix_ready,
    input  logic [gge_pkg::PIXEL_W-1:0]       i_pix_data,
    // Queue write side
    output logic                              o_push,
    output gge_pkg::t_entry                   o_entry,
    input  logic                              i_q_full
);
    import gge_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int RESET_LAST_COL =
        ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

    // Effective geometry, stored as last column and last row
    logic [CW-1:0]    r_last_col;
    logic [ROW_W-1:0] r_last_row;
    logic [XW-1:0]    cfg_width;
    logic [XW-1:0]    eff_width;

    // Position of the next pixel
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // Gray stage
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic [SUM_W-1:0] r_s1_sum;
    logic [LEVEL_W-1:0] r_rd_data;
    logic [LEVEL_W-1:0] r_prev_right;
    logic [LEVEL_W-1:0] r_first_gray;

    logic [LEVEL_W-1:0] line_mem [MAX_WIDTH];

    logic               accept;
    logic               s1_leave;
    logic [CW-1:0]      rd_addr;
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [LEVEL_W-1:0] gray;
    logic [LEVEL_W-1:0] center;
    logic [LEVEL_W-1:0] diff_right;
    logic [LEVEL_W-1:0] diff_below;
    logic [LEVEL_W:0]   grad_sum;
    logic [LEVEL_W-1:0] grad_level;
    logic               s1_last_col;
    t_kind              s1_kind;

    // Clamp the requested width into 1 .. MAX_WIDTH
    always_comb begin
        cfg_width = XW'(i_cfg_data);
        if (cfg_width == '0) begin
            eff_width = XW'(1);
        end else if (cfg_width > XW'(MAX_WIDTH)) begin
            eff_width = XW'(MAX_WIDTH);
        end else begin
            eff_width = cfg_width;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RESET_LAST_COL);
            r_last_row <= ROW_W'(RESET_HEIGHT - 1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_last_col <= CW'(eff_width - XW'(1));
                end
                CFG_FRAME_HEIGHT: begin
                    r_last_row <= (i_cfg_data == '0) ? '0 : i_cfg_data - 1'b1;
                end
                default: begin
                    r_last_col <= r_last_col;
                end
            endcase
        end
    end

    // A pixel enters when the gray stage is empty or moves on this cycle
    assign accept      = i_pix_valid && o_pix_ready;
    assign o_pix_ready = !r_s1_valid || s1_leave;

    // Raster position; any configuration write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_wr_en) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Gray stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_leave) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_sum <= SUM_W'(i_pix_data[CHAN_W-1:0])
                      + SUM_W'(i_pix_data[2*CHAN_W-1:CHAN_W])
                      + SUM_W'(i_pix_data[3*CHAN_W-1:2*CHAN_W]);
        end
    end

    // Line buffer: the entry right of the new pixel is read as it enters.
    // A write to the same entry in that cycle is forwarded.
    assign rd_addr = r_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            line_mem[r_s1_col] <= gray;
        end
        if (accept) begin
            if (s1_leave && (r_s1_col == rd_addr)) begin
                r_rd_data <= gray;
            end else begin
                r_rd_data <= line_mem[rd_addr];
            end
        end
    end

    // The value above the current pixel: the first column is kept aside,
    // the others were read one pixel earlier as the right neighbor.
    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            r_prev_right <= r_rd_data;
            if (r_s1_col == '0) begin
                r_first_gray <= gray;
            end
        end
    end

    // Gray value and gradient
    assign gray_prod = GRAY_PROD_W'(r_s1_sum) * GRAY_PROD_W'(GRAY_RECIP);
    assign gray      = gray_prod[GRAY_SHIFT +: LEVEL_W];
    assign center    = (r_s1_col == '0) ? r_first_gray : r_prev_right;

    always_comb begin
        diff_right = (center > r_rd_data) ? center - r_rd_data : r_rd_data - center;
        diff_below = (center > gray) ? center - gray : gray - center;
        grad_sum   = {1'b0, diff_right} + {1'b0, diff_below};
        // 2 * sum clamped to 255, then inverted
        if (grad_sum > (LEVEL_W + 1)'(LEVEL_MAX >> 1)) begin
            grad_level = '0;
        end else begin
            grad_level = LEVEL_MAX - {grad_sum[LEVEL_W-2:0], 1'b0};
        end
    end

    // Classification
    assign s1_last_col = (r_s1_col == r_last_col);

    always_comb begin
        if (r_last_row == '0) begin
            s1_kind = KIND_SELF;
        end else if (r_s1_row == '0) begin
            s1_kind = KIND_NONE;
        end else if (r_s1_row == r_last_row) begin
            s1_kind = KIND_BOTH;
        end else begin
            s1_kind = KIND_ABOVE;
        end
    end

    assign s1_leave = r_s1_valid && ((s1_kind == KIND_NONE) || !i_q_full);
    assign o_push   = r_s1_valid && (s1_kind != KIND_NONE) && !i_q_full;

    always_comb begin
        o_entry.col         = COL_MAX_W'(r_s1_col);
        o_entry.row         = r_s1_row;
        o_entry.above_level = s1_last_col ? center : grad_level;
        o_entry.gray        = gray;
        o_entry.kind        = s1_kind;
    end

endmodule

// ----- rtl/core/gge_queue.sv -----
// ----------------------------------------------------------------------------
// Gray gradient edge map: entry queue
// Four-entry queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module gge_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gge_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output gge_pkg::t_entry o_entry
);
    import gge_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_entry          r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;

    assign o_full  = (r_count == (PW + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/gge_back.sv -----
// ----------------------------------------------------------------------------
// Gray gradient edge map: result sequencer
// Takes queue entries into an output register and emits one or two
// results per entry.
// ----------------------------------------------------------------------------
module gge_back #(
    parameter int CW = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  gge_pkg::t_entry               i_q_entry,
    output logic                          o_pop,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [CW-1:0]                 o_res_col,
    output logic [gge_pkg::ROW_W-1:0]     o_res_row,
    output logic [gge_pkg::LEVEL_W-1:0]   o_res_level,
    output logic                          o_res_last
);
    import gge_pkg::*;

    logic   r_valid;
    logic   r_second;
    t_entry r_entry;
    logic   transfer;
    logic   finishing;
    logic   show_above;

    assign transfer  = r_valid && i_res_ready;
    // The entry is done after this transfer unless a second result follows.
    assign finishing = (r_entry.kind != KIND_BOTH) || r_second;
    assign o_pop     = i_q_valid && (!r_valid || (transfer && finishing));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (transfer) begin
            if (finishing) begin
                r_valid <= 1'b0;
            end else begin
                r_second <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_q_entry;
        end
    end

    // Result selection: the pixel above first, then the pixel itself
    assign show_above = (r_entry.kind == KIND_ABOVE)
                     || ((r_entry.kind == KIND_BOTH) && !r_second);

    assign o_res_valid = r_valid;
    assign o_res_col   = CW'(r_entry.col);
    assign o_res_row   = show_above ? r_entry.row - 1'b1 : r_entry.row;
    assign o_res_level = show_above ? r_entry.above_level : r_entry.gray;
    assign o_res_last  = finishing;

endmodule

// ----- rtl/core/gray_gradient_edge_map.sv -----
// ----------------------------------------------------------------------------
// Gray gradient edge map
// Streaming forward-difference edge detector over raster-order RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel, one transfer per pixel, in raster
// order. Each becomes gray = (r + g + b) / 3. A pixel that is not in the
// last row or column gives 255 - min(255, 2 * (|c - right| + |c - below|));
// last-row and last-column pixels give their gray value. Results leave on
// the m_axis channel with their column and row; tlast marks the final
// result caused by one input pixel.
// The result for pixel (x, y) is caused by pixel (x, y + 1). It passes
// through the gray stage register, the queue and the output register
// before it is presented.
// Throughput is one pixel per cycle while the output accepts results; in
// the last row each pixel gives two results, so the output port limits
// the rate there. A one-row frame gives one gray result per pixel.
// Configuration writes (index 0: frame width, index 1: frame height) take
// effect at once and restart the frame at column 0, row 0.
// Reset restores 640 x 480, empties the pipeline and the queue, and
// restarts the frame; the line buffer is not cleared. When the receiver
// stalls, a four-entry queue absorbs the work, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module gray_gradient_edge_map #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration
    input  logic                                  i_cfg_wr_en,
    input  logic [gge_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gge_pkg::CFG_W-1:0]             i_cfg_data,
    // Pixel input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: red [7:0], green [15:8], blue [23:16]
    input  logic [gge_pkg::PIXEL_W-1:0]           s_axis_tdata,
    // Result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: out_col, out_row, level from bit 0 up, zero filled to bytes
    output logic [(($clog2(MAX_WIDTH) + 20 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import gge_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int OUT_W = ((CW + ROW_W + LEVEL_W + 7) / 8) * 8;

    logic               push;
    t_entry             push_entry;
    logic               q_full;
    logic               q_valid;
    t_entry             q_entry;
    logic               pop;
    logic [CW-1:0]      res_col;
    logic [ROW_W-1:0]   res_row;
    logic [LEVEL_W-1:0] res_level;

    // Front end: position, line buffer, gray and gradient
    gge_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_pix_data  (s_axis_tdata),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_q_full    (q_full)
    );

    // Queue between classification and result output
    gge_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Result sequencer with output register
    gge_back #(
        .CW (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_col   (res_col),
        .o_res_row   (res_row),
        .o_res_level (res_level),
        .o_res_last  (m_axis_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = OUT_W'({res_level, res_row, res_col});

endmodule
